// ===== src/nmea_pkg.sv =====
// Package with the codes, tables and helper functions of the NMEA sentence framer.
package nmea_pkg;

  // Default line length limit in characters.
  localparam int MaxSentence = 128;

  // Character codes the framer looks for.
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;

  // Minimum number of buffered characters for a sentence to be checked.
  localparam int MinLength = 4;

  // Result status codes.
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StShort    = 3'd1;
  localparam logic [2:0] StField    = 3'd2;
  localparam logic [2:0] StMismatch = 3'd3;
  localparam logic [2:0] StUnknown  = 3'd4;

  // Sentence type codes; codes 0 to 7 are the three-letter types in table order.
  localparam logic [3:0] TypePubx = 4'd8;
  localparam logic [3:0] TypeNone = 4'd9;
  localparam int NumThree = 8;

  // Candidate mask with one bit for each type, PUBX in the top bit.
  localparam logic [8:0] AllCandidates = 9'h1FF;

  // Characters 3 to 5 of each three-letter type: GGA RMC GLL GSV VTG GSA ZDA TXT.
  localparam logic [7:0] ThreeLetter [NumThree][3] = '{
    '{8'h47, 8'h47, 8'h41},
    '{8'h52, 8'h4D, 8'h43},
    '{8'h47, 8'h4C, 8'h4C},
    '{8'h47, 8'h53, 8'h56},
    '{8'h56, 8'h54, 8'h47},
    '{8'h47, 8'h53, 8'h41},
    '{8'h5A, 8'h44, 8'h41},
    '{8'h54, 8'h58, 8'h54}
  };

  // Characters 1 to 4 of the proprietary PUBX type.
  localparam logic [7:0] PubxName [4] = '{8'h50, 8'h55, 8'h42, 8'h58};

  // Framer phase.
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_BODY,
    PH_HEX
  } phase_t;

  // One result item; the last field sits in the lowest bits.
  typedef struct packed {
    logic [1:0]  pad;
    logic [15:0] overflow_count;
    logic [15:0] mismatch_count;
    logic [15:0] ok_count;
    logic [6:0]  sentence_length;
    logic [7:0]  read_checksum;
    logic [7:0]  calc_checksum;
    logic [3:0]  sentence_type;
    logic [2:0]  status;
  } result_t;

  // Hex digit decode: bit 4 is set when the character is a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d = {1'b1, c[3:0] + 4'd9};
    end
    return d;
  endfunction

endpackage

// ===== src/nmea_sentence_framer_checker_core.sv =====
// Top level of the NMEA sentence framer and checksum checker.
//
// The block takes a received character stream on the in_ channel, one item
// per byte, and gives one result item on the out_ channel for every line that
// starts with '$' and ends with CR or LF. Bytes before a '$' are dropped.
// The body after '$' is XORed up to the first '*', the two hex digits after it
// are read back, and the line is classified by status and sentence type.
// A line that reaches MAX_SENTENCE characters before its line end gives no result
// and is counted in overflow_count instead.
//
// A new item is accepted in every cycle unless in_tready is low. The result of a
// line end is registered into the result register, or the skid register if one waits.
// A result register and a skid register part the two channels: the block keeps
// accepting while one result waits, and drops in_tready only while two results
// are held. Reset clears the framer state, the counters and both result slots.
module nmea_sentence_framer_checker_core #(
  parameter int MAX_SENTENCE = nmea_pkg::MaxSentence
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], sentence_type[6:3], calc_checksum[14:7], read_checksum[22:15],
  // sentence_length[29:23], ok_count[45:30], mismatch_count[61:46],
  // overflow_count[77:62], zero fill[79:78]
  output logic [79:0] out_tdata
);

  localparam int PosW = $clog2(MAX_SENTENCE + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_SENTENCE);

  // Framer state.
  nmea_pkg::phase_t phase_r, phase_nxt;
  logic [PosW-1:0]  pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [8:0]       cand_r, cand_nxt;
  logic [7:0]       hex_r, hex_nxt;
  logic [1:0]       digits_r, digits_nxt;
  logic             hex_bad_r, hex_bad_nxt;
  logic [15:0]      good_r, good_nxt;
  logic [15:0]      bad_r, bad_nxt;
  logic [15:0]      drop_r, drop_nxt;

  // Result slots.
  nmea_pkg::result_t out_r, out_nxt, skid_r, skid_nxt, res;
  logic              out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic              res_v;

  logic             accept;
  logic             pop;
  logic [3:0]       stype;
  logic             field_ok;
  logic [4:0]       dig;

  assign accept     = in_tvalid && in_tready;
  assign pop        = out_v_r && out_tready;
  assign in_tready  = !skid_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;
  assign dig        = nmea_pkg::hex_digit(in_tdata);

  // Sentence type from the candidates still matching.
  always_comb begin
    stype = nmea_pkg::TypeNone;
    if (pos_r >= PosW'(5) && cand_r[8]) begin
      stype = nmea_pkg::TypePubx;
    end
    if (pos_r >= PosW'(6)) begin
      for (int k = nmea_pkg::NumThree - 1; k >= 0; k--) begin
        if (cand_r[k]) begin
          stype = 4'(k);
        end
      end
    end
  end

  assign field_ok = (phase_r == nmea_pkg::PH_HEX) && (digits_r == 2'd2) && !hex_bad_r;

  // Per-byte framing, checksum and classification.
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    xor_nxt     = xor_r;
    cand_nxt    = cand_r;
    hex_nxt     = hex_r;
    digits_nxt  = digits_r;
    hex_bad_nxt = hex_bad_r;
    good_nxt    = good_r;
    bad_nxt     = bad_r;
    drop_nxt    = drop_r;
    res_v       = 1'b0;
    res         = '0;

    if (accept) begin
      if (phase_r == nmea_pkg::PH_HUNT) begin
        if (in_tdata == nmea_pkg::ChDollar) begin
          phase_nxt   = nmea_pkg::PH_BODY;
          pos_nxt     = PosW'(1);
          xor_nxt     = 8'd0;
          cand_nxt    = nmea_pkg::AllCandidates;
          hex_nxt     = 8'd0;
          digits_nxt  = 2'd0;
          hex_bad_nxt = 1'b0;
        end
      end else if (in_tdata == nmea_pkg::ChCr || in_tdata == nmea_pkg::ChLf) begin
        // Line end: drop an overlong line, otherwise give a result.
        if (pos_r >= PosMax) begin
          drop_nxt = drop_r + 16'd1;
        end else begin
          res_v                 = 1'b1;
          res.sentence_type     = stype;
          res.calc_checksum     = xor_r;
          res.sentence_length   = 7'(pos_r);
          if (pos_r < PosW'(nmea_pkg::MinLength)) begin
            res.status = nmea_pkg::StShort;
          end else if (!field_ok) begin
            res.status = nmea_pkg::StField;
          end else begin
            res.read_checksum = hex_r;
            if (hex_r != xor_r) begin
              res.status = nmea_pkg::StMismatch;
              bad_nxt    = bad_r + 16'd1;
            end else begin
              good_nxt   = good_r + 16'd1;
              res.status = (stype == nmea_pkg::TypeNone) ? nmea_pkg::StUnknown
                                                         : nmea_pkg::StOk;
            end
          end
          res.ok_count       = good_nxt;
          res.mismatch_count = bad_nxt;
        end
        res.overflow_count = drop_nxt;
        phase_nxt = nmea_pkg::PH_HUNT;
      end else if (pos_r >= PosMax) begin
        // Buffer full: the line is dropped.
        drop_nxt  = drop_r + 16'd1;
        phase_nxt = nmea_pkg::PH_HUNT;
      end else begin
        // Type matching on characters 1 to 5.
        if (pos_r >= PosW'(3) && pos_r <= PosW'(5)) begin
          for (int k = 0; k < nmea_pkg::NumThree; k++) begin
            if (nmea_pkg::ThreeLetter[k][2'(pos_r - PosW'(3))] != in_tdata) begin
              cand_nxt[k] = 1'b0;
            end
          end
        end
        if (pos_r >= PosW'(1) && pos_r <= PosW'(4)) begin
          if (nmea_pkg::PubxName[2'(pos_r - PosW'(1))] != in_tdata) begin
            cand_nxt[8] = 1'b0;
          end
        end
        pos_nxt = pos_r + PosW'(1);

        // Body XOR or checksum digits.
        if (phase_r == nmea_pkg::PH_BODY) begin
          if (in_tdata == nmea_pkg::ChStar) begin
            phase_nxt = nmea_pkg::PH_HEX;
          end else begin
            xor_nxt = xor_r ^ in_tdata;
          end
        end else if (!dig[4] || digits_r == 2'd2) begin
          hex_bad_nxt = 1'b1;
        end else begin
          hex_nxt    = {hex_r[3:0], dig[3:0]};
          digits_nxt = digits_r + 2'd1;
        end
      end
    end
  end

  // Result register and skid slot.
  always_comb begin
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      out_nxt    = skid_r;
      out_v_nxt  = skid_v_r;
      skid_v_nxt = 1'b0;
    end
    if (res_v) begin
      if (!out_v_r || (pop && !skid_v_r)) begin
        out_nxt   = res;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= nmea_pkg::PH_HUNT;
      pos_r     <= '0;
      xor_r     <= '0;
      cand_r    <= '0;
      hex_r     <= '0;
      digits_r  <= '0;
      hex_bad_r <= 1'b0;
      good_r    <= '0;
      bad_r     <= '0;
      drop_r    <= '0;
      out_v_r   <= 1'b0;
      skid_v_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      xor_r     <= xor_nxt;
      cand_r    <= cand_nxt;
      hex_r     <= hex_nxt;
      digits_r  <= digits_nxt;
      hex_bad_r <= hex_bad_nxt;
      good_r    <= good_nxt;
      bad_r     <= bad_nxt;
      drop_r    <= drop_nxt;
      out_v_r   <= out_v_nxt;
      skid_v_r  <= skid_v_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the NMEA sentence framer and checksum checker.
module testbench;

  // Idle chance in percent, and a window of cycles with no idling on either side.
  localparam int IdlePercent = 23;
  localparam int QuietFrom = 300;
  localparam int QuietTo = 600;
  // Cycles with no item moving on either side before the run is abandoned.
  localparam int StallLimit = 2000;
  // Cycles to let the block settle after the last expected result.
  localparam int DrainCycles = 8;

  // Characters 3 to 5 of the three-letter types, in type code order.
  localparam logic [23:0] TypeLetters [8] = '{
    "GGA", "RMC", "GLL", "GSV", "VTG", "GSA", "ZDA", "TXT"
  };
  // Characters 1 to 4 of the proprietary type.
  localparam logic [31:0] PubxLetters = "PUBX";
  // Characters just outside the hex digit ranges, plus a few others.
  localparam logic [7:0] BadChars [8] = '{
    8'h47, 8'h67, 8'h2F, 8'h3A, 8'h40, 8'h60, 8'h78, 8'h20
  };

  // How a generated sentence ends after its body.
  typedef enum int {
    TAIL_GOOD,
    TAIL_WRONG,
    TAIL_NO_STAR,
    TAIL_ONE_DIGIT,
    TAIL_BAD_HEX,
    TAIL_EXTRA,
    TAIL_TWO_STARS
  } tail_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [79:0] out_tdata;

  // Bytes waiting to be sent and the line results still to arrive.
  logic [7:0]          rx_bytes [$];
  nmea_pkg::result_t   line_results [$];
  // Body of the sentence being built by the stimulus tasks.
  logic [7:0] body_q [$];

  // Framer state as the predictor tracks it.
  nmea_pkg::phase_t fr_phase = nmea_pkg::PH_HUNT;
  int          line_pos = 0;
  logic [7:0]  line_xor = 8'h00;
  logic [8:0]  cand_mask = 9'h000;
  logic [7:0]  digits_val = 8'h00;
  int          digits_seen = 0;
  bit          digits_bad = 1'b0;
  logic [15:0] ok_total = 16'h0000;
  logic [15:0] mismatch_total = 16'h0000;
  logic [15:0] overflow_total = 16'h0000;

  int                errors = 0;
  int                cycle_count = 0;
  int                stall_cycles = 0;
  bit                byte_taken = 1'b0;
  nmea_pkg::result_t got;
  nmea_pkg::result_t want;

  nmea_sentence_framer_checker_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Clear the per-line state, leaving the counters alone.
  function automatic void clear_line();
    fr_phase = nmea_pkg::PH_HUNT;
    line_pos = 0;
    line_xor = 8'h00;
    cand_mask = 9'h000;
    digits_val = 8'h00;
    digits_seen = 0;
    digits_bad = 1'b0;
  endfunction

  // Advance the predictor by one accepted byte; a line end queues its result.
  task automatic frame_byte(input logic [7:0] c);
    nmea_pkg::result_t r;
    logic [3:0] kind;
    logic [3:0] nib;
    bit         is_hex;
    bit         field_ok;
    int         k;
    if (fr_phase == nmea_pkg::PH_HUNT) begin
      if (c == nmea_pkg::ChDollar) begin
        clear_line();
        fr_phase = nmea_pkg::PH_BODY;
        cand_mask = nmea_pkg::AllCandidates;
        line_pos = 1;
      end
    end else if (c == nmea_pkg::ChCr || c == nmea_pkg::ChLf) begin
      if (line_pos >= nmea_pkg::MaxSentence) begin
        overflow_total++;
      end else begin
        // A three-letter type wins over the proprietary one; lowest code first.
        kind = nmea_pkg::TypeNone;
        if (line_pos >= 5 && cand_mask[8]) kind = nmea_pkg::TypePubx;
        if (line_pos >= 6) begin
          for (k = 7; k >= 0; k--) begin
            if (cand_mask[k]) kind = k[3:0];
          end
        end
        field_ok = (fr_phase == nmea_pkg::PH_HEX) && digits_seen == 2 && !digits_bad;
        r = '0;
        r.sentence_type = kind;
        r.calc_checksum = line_xor;
        r.sentence_length = line_pos[6:0];
        if (line_pos < nmea_pkg::MinLength) begin
          r.status = nmea_pkg::StShort;
        end else if (!field_ok) begin
          r.status = nmea_pkg::StField;
        end else begin
          r.read_checksum = digits_val;
          if (digits_val != line_xor) begin
            r.status = nmea_pkg::StMismatch;
            mismatch_total++;
          end else begin
            ok_total++;
            r.status = (kind == nmea_pkg::TypeNone) ? nmea_pkg::StUnknown
                                                     : nmea_pkg::StOk;
          end
        end
        r.ok_count = ok_total;
        r.mismatch_count = mismatch_total;
        r.overflow_count = overflow_total;
        line_results.push_back(r);
      end
      clear_line();
    end else if (line_pos >= nmea_pkg::MaxSentence) begin
      overflow_total++;
      clear_line();
    end else begin
      // Drop the type candidates that this character rules out.
      if (line_pos >= 3 && line_pos <= 5) begin
        for (k = 0; k < 8; k++) begin
          if (TypeLetters[k][(23 - 8 * (line_pos - 3)) -: 8] != c) cand_mask[k] = 1'b0;
        end
      end
      if (line_pos >= 1 && line_pos <= 4) begin
        if (PubxLetters[(31 - 8 * (line_pos - 1)) -: 8] != c) cand_mask[8] = 1'b0;
      end
      line_pos++;
      if (fr_phase == nmea_pkg::PH_BODY) begin
        if (c == nmea_pkg::ChStar) fr_phase = nmea_pkg::PH_HEX;
        else line_xor ^= c;
      end else begin
        is_hex = 1'b1;
        nib = 4'h0;
        if (c >= "0" && c <= "9") nib = 4'(c - 8'h30);
        else if (c >= "A" && c <= "F") nib = 4'(c - 8'h37);
        else if (c >= "a" && c <= "f") nib = 4'(c - 8'h57);
        else is_hex = 1'b0;
        if (!is_hex || digits_seen >= 2) begin
          digits_bad = 1'b1;
        end else begin
          digits_val = {digits_val[3:0], nib};
          digits_seen++;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  function automatic bit idle_roll();
    return (cycle_count < QuietFrom || cycle_count >= QuietTo) &&
           $urandom_range(99) < IdlePercent;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (lower ? 8'h57 : 8'h37) + {4'h0, n};
  endfunction

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  // Two-letter talker: GP half the time, otherwise random capitals.
  task automatic add_talker();
    if ($urandom_range(1) == 0) begin
      add_text("GP");
    end else begin
      body_q.push_back(8'h41 + 8'($urandom_range(25)));
      body_q.push_back(8'h41 + 8'($urandom_range(25)));
    end
  endtask

  task automatic add_type(input int k);
    int j;
    for (j = 0; j < 3; j++) body_q.push_back(TypeLetters[k][(23 - 8 * j) -: 8]);
  endtask

  // Random field content: mostly printable, sometimes any byte but '*' and line ends.
  task automatic add_fields(input int n);
    int i;
    logic [7:0] b;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) b = 8'($urandom_range(255));
      else b = 8'($urandom_range(8'h20, 8'h7E));
      if (b == nmea_pkg::ChStar || b == nmea_pkg::ChCr || b == nmea_pkg::ChLf) b = ",";
      body_q.push_back(b);
    end
  endtask

  // Send '$', the built body, the chosen checksum tail and a CR or LF.
  task automatic emit_line(input tail_t tail);
    logic [7:0] sum;
    logic [7:0] wrong;
    bit         lower;
    sum = 8'h00;
    lower = 1'($urandom_range(1));
    rx_bytes.push_back(nmea_pkg::ChDollar);
    foreach (body_q[i]) begin
      rx_bytes.push_back(body_q[i]);
      sum ^= body_q[i];
    end
    body_q.delete();
    case (tail)
      TAIL_GOOD, TAIL_EXTRA: begin
        rx_bytes.push_back(nmea_pkg::ChStar);
        rx_bytes.push_back(hex_char(sum[7:4], lower));
        rx_bytes.push_back(hex_char(sum[3:0], lower));
        if (tail == TAIL_EXTRA) rx_bytes.push_back(hex_char(4'($urandom_range(15)), lower));
      end
      TAIL_WRONG: begin
        wrong = sum ^ 8'($urandom_range(1, 255));
        rx_bytes.push_back(nmea_pkg::ChStar);
        rx_bytes.push_back(hex_char(wrong[7:4], lower));
        rx_bytes.push_back(hex_char(wrong[3:0], lower));
      end
      TAIL_ONE_DIGIT: begin
        rx_bytes.push_back(nmea_pkg::ChStar);
        rx_bytes.push_back(hex_char(sum[3:0], lower));
      end
      TAIL_BAD_HEX: begin
        rx_bytes.push_back(nmea_pkg::ChStar);
        rx_bytes.push_back(hex_char(sum[7:4], lower));
        rx_bytes.push_back(BadChars[3'($urandom_range(7))]);
      end
      TAIL_TWO_STARS: begin
        rx_bytes.push_back(nmea_pkg::ChStar);
        rx_bytes.push_back(hex_char(sum[7:4], lower));
        rx_bytes.push_back(nmea_pkg::ChStar);
      end
      default: begin
      end
    endcase
    rx_bytes.push_back($urandom_range(1) ? nmea_pkg::ChCr : nmea_pkg::ChLf);
  endtask

  // Driver: present the next byte at the falling edge once the last one is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || byte_taken) begin
        if (rx_bytes.size() != 0 && !idle_roll()) begin
          in_tdata <= rx_bytes.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= !idle_roll();
    end
  end

  // Monitor: predict from accepted bytes and check each accepted result.
  always @(posedge clk) begin
    cycle_count++;
    byte_taken = rst_n && in_tvalid && in_tready;
    if (byte_taken) frame_byte(in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (line_results.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, out_tdata);
        errors++;
      end else begin
        want = line_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("sentence_type", 32'(want.sentence_type), 32'(got.sentence_type));
        check_field("calc_checksum", 32'(want.calc_checksum), 32'(got.calc_checksum));
        check_field("read_checksum", 32'(want.read_checksum), 32'(got.read_checksum));
        check_field("sentence_length", 32'(want.sentence_length),
                    32'(got.sentence_length));
        check_field("ok_count", 32'(want.ok_count), 32'(got.ok_count));
        check_field("mismatch_count", 32'(want.mismatch_count), 32'(got.mismatch_count));
        check_field("overflow_count", 32'(want.overflow_count), 32'(got.overflow_count));
        check_field("zero fill", 32'(want.pad), 32'(got.pad));
      end
    end
    // Watchdog on cycles in which nothing moves.
    if (rst_n) begin
      if (byte_taken || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int    k;
    int    t;
    int    r;
    int    n;
    int    start_size;

    // Noise while hunting, with both extreme byte values.
    rx_bytes.push_back(nmea_pkg::ChCr);
    rx_bytes.push_back(nmea_pkg::ChLf);
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    rx_bytes.push_back("A");
    // Too short: the lone dollar sign and a three-character line.
    emit_line(TAIL_NO_STAR);
    add_text("GP");
    emit_line(TAIL_NO_STAR);
    // Shortest checked line, no type.
    emit_line(TAIL_GOOD);
    // Every known type.
    for (k = 0; k < 8; k++) begin
      add_text("GP");
      add_type(k);
      add_text(",");
      add_fields(4);
      emit_line(TAIL_GOOD);
    end
    add_text("PUBX,00,");
    add_fields(3);
    emit_line(TAIL_GOOD);
    add_text("PUB");
    emit_line(TAIL_GOOD);
    add_text("GPXYZ,1");
    emit_line(TAIL_GOOD);
    // Every broken checksum field and a mismatch.
    for (t = TAIL_WRONG; t <= TAIL_TWO_STARS; t++) begin
      add_text("GPGGA,");
      add_fields(2);
      emit_line(tail_t'(t));
    end
    // Zero byte, all-ones byte and a dollar sign inside the body.
    add_text("GPTXT,");
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    body_q.push_back(nmea_pkg::ChDollar);
    emit_line(TAIL_GOOD);
    // Longest line that still gives a result, a line end at the limit,
    // and a line that runs past the limit.
    add_text("GPGSV,");
    add_fields(117);
    emit_line(TAIL_GOOD);
    add_fields(127);
    emit_line(TAIL_NO_STAR);
    add_fields(131);
    emit_line(TAIL_NO_STAR);

    // Random part: mostly well-formed sentences, some broken ones and noise.
    start_size = rx_bytes.size();
    while (rx_bytes.size() - start_size < 120) begin
      r = $urandom_range(99);
      if (r < 8) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) rx_bytes.push_back(8'($urandom_range(255)));
      end else if (r < 10) begin
        add_fields($urandom_range(124, 132));
        emit_line(tail_t'($urandom_range(TAIL_GOOD, TAIL_TWO_STARS)));
      end else begin
        k = $urandom_range(10);
        if (k < 8) begin
          add_talker();
          add_type(k);
        end else if (k == 8) begin
          add_text("PUBX");
        end else if (k == 9) begin
          n = $urandom_range(5);
          for (t = 0; t < n; t++) body_q.push_back(8'h41 + 8'($urandom_range(25)));
        end else begin
          add_talker();
          for (t = 0; t < 3; t++) body_q.push_back(8'h41 + 8'($urandom_range(25)));
        end
        if (body_q.size() != 0) add_text(",");
        add_fields($urandom_range(12));
        if ($urandom_range(99) < 70) emit_line(TAIL_GOOD);
        else emit_line(tail_t'($urandom_range(TAIL_WRONG, TAIL_TWO_STARS)));
      end
    end

    // Reset, released at a falling edge.
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    while (rx_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (line_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (line_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, line_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/nmea_pkg.sv
src/nmea_sentence_framer_checker_core.sv
sim/testbench.sv
